@@ design/annexb_parameter_set_locator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// annexb parameter set locator - assertion macros
// shared property forms for the checker, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ANNEXB_PARAMETER_SET_LOCATOR_UNIT_DEFINES_SVH
`define ANNEXB_PARAMETER_SET_LOCATOR_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define APSL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define APSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/apsl_pkg.sv @@
// ----------------------------------------------------------------------------
// apsl_pkg
// constants, widths, nal type codes and the word type of the locator
// ----------------------------------------------------------------------------
package apsl_pkg;

    localparam int MAX_BYTES  = 1048576;
    localparam int MAX_NALS   = 1024;

    localparam int POS_W      = 21;
    localparam int OFF_W      = 20;
    localparam int LEN_W      = 21;
    localparam int HC_W       = 11;
    localparam int TYPE_W     = 6;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_HEVC_MODE = 1'b0;

    localparam logic [TYPE_W-1:0] H264_SPS = 6'd7;
    localparam logic [TYPE_W-1:0] H264_PPS = 6'd8;
    localparam logic [TYPE_W-1:0] HEVC_VPS = 6'd32;
    localparam logic [TYPE_W-1:0] HEVC_SPS = 6'd33;
    localparam logic [TYPE_W-1:0] HEVC_PPS = 6'd34;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } word_t;

endpackage

@@ design/apsl_in_if.sv @@
// ----------------------------------------------------------------------------
// apsl_in_if
// byte channel of the locator: one access unit byte per word
// ----------------------------------------------------------------------------
interface apsl_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

@@ design/apsl_out_if.sv @@
// ----------------------------------------------------------------------------
// apsl_out_if
// result channel of the locator: one word per buffer
// ----------------------------------------------------------------------------
interface apsl_out_if;

    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [apsl_pkg::OFF_W-1:0] start_offset;
    logic [apsl_pkg::LEN_W-1:0] total_length;
    logic                       too_long;

    modport source (output valid, output found, output start_offset,
                    output total_length, output too_long, input ready);
    modport sink   (input valid, input found, input start_offset,
                    input total_length, input too_long, output ready);

endinterface

@@ design/apsl_cfg.sv @@
// ----------------------------------------------------------------------------
// apsl_cfg
// apb register file holding the codec mode select
// ----------------------------------------------------------------------------
module apsl_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [apsl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [apsl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [apsl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic                            hevc_mode
);

    logic                              hevc_mode_reg;
    logic [apsl_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                              wr_en;

    assign reg_idx = paddr[apsl_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hevc_mode_reg <= 1'b0;
        end
        else if (wr_en && (reg_idx == apsl_pkg::REG_HEVC_MODE))
        begin
            hevc_mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            apsl_pkg::REG_HEVC_MODE: prdata[0] = hevc_mode_reg;
            default:                 prdata    = '0;
        endcase
    end

    assign hevc_mode = hevc_mode_reg;

endmodule

@@ design/apsl_in_stage.sv @@
// ----------------------------------------------------------------------------
// apsl_in_stage
// input register in front of the scan core, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module apsl_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    apsl_in_if.sink           bytes,
    input  logic              take,
    output logic              word_valid,
    output apsl_pkg::word_t   word
);

    logic            valid_reg;
    apsl_pkg::word_t word_reg;
    logic            load;

    assign bytes.ready = !valid_reg || take;
    assign load        = bytes.valid && bytes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg.data_byte <= bytes.data_byte;
            word_reg.last_byte <= bytes.last_byte;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

@@ design/apsl_core.sv @@
// ----------------------------------------------------------------------------
// apsl_core
// start code scan, nal bookkeeping, group match and the result register
// ----------------------------------------------------------------------------
module apsl_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hevc_mode,
    input  logic              word_valid,
    input  apsl_pkg::word_t   word,
    output logic              take,
    apsl_out_if.source        results
);

    typedef struct packed {
        logic                       stop;
        logic [apsl_pkg::OFF_W-1:0] best_off;
        logic [apsl_pkg::LEN_W-1:0] best_len;
    } match_t;

    // closes the newest nal ending at nal_end
    function automatic match_t close_nal(
        input match_t                      cur,
        input logic                        mode,
        input logic [apsl_pkg::HC_W-1:0]   hc,
        input logic [apsl_pkg::TYPE_W-1:0] t0,
        input logic [apsl_pkg::TYPE_W-1:0] t1,
        input logic [apsl_pkg::TYPE_W-1:0] t2,
        input logic [apsl_pkg::OFF_W-1:0]  off1,
        input logic [apsl_pkg::OFF_W-1:0]  off2,
        input logic [apsl_pkg::POS_W-1:0]  nal_end,
        input logic [apsl_pkg::POS_W-1:0]  nal_len
    );
        match_t res;
        res = cur;
        if ((hc >= apsl_pkg::HC_W'(2)) && !cur.stop)
        begin
            if (nal_len == '0)
            begin
                res.stop = 1'b1;
            end
            else if (mode)
            begin
                if ((t0 == apsl_pkg::HEVC_PPS) && (t1 == apsl_pkg::HEVC_SPS) &&
                    (hc >= apsl_pkg::HC_W'(3)) && (t2 == apsl_pkg::HEVC_VPS))
                begin
                    res.best_off = off2;
                    res.best_len = nal_end - apsl_pkg::POS_W'(off2);
                end
            end
            else if ((t0 == apsl_pkg::H264_PPS) && (t1 == apsl_pkg::H264_SPS))
            begin
                res.best_off = off1;
                res.best_len = nal_end - apsl_pkg::POS_W'(off1);
            end
        end
        return res;
    endfunction

    logic [7:0]                  win_reg   [4];
    logic [7:0]                  win_next  [4];
    logic [apsl_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [apsl_pkg::HC_W-1:0]   hc_reg, hc_next;
    logic [apsl_pkg::TYPE_W-1:0] types_reg [3];
    logic [apsl_pkg::TYPE_W-1:0] types_next[3];
    logic [apsl_pkg::OFF_W-1:0]  offs_reg  [3];
    logic [apsl_pkg::OFF_W-1:0]  offs_next [3];
    logic                        stop_reg;
    logic [apsl_pkg::OFF_W-1:0]  best_off_reg;
    logic [apsl_pkg::LEN_W-1:0]  best_len_reg;
    logic                        ovf_reg, ovf_next;

    logic                        out_valid_reg;
    logic                        found_reg;
    logic [apsl_pkg::OFF_W-1:0]  start_offset_reg;
    logic [apsl_pkg::LEN_W-1:0]  total_length_reg;
    logic                        too_long_reg;

    logic                        ovf_now;
    logic                        hdr;
    logic [apsl_pkg::TYPE_W-1:0] typ;
    logic [2:0]                  cut;
    logic [apsl_pkg::POS_W-1:0]  end1, len1, len2;
    match_t                      cur, cl1, cl2;
    logic                        final_ok;
    logic                        found_c;
    logic [apsl_pkg::OFF_W-1:0]  off_c;
    logic [apsl_pkg::LEN_W-1:0]  len_c;

    assign take = word_valid && (!word.last_byte || !out_valid_reg || results.ready);

    always_comb
    begin
        ovf_now = pos_reg >= apsl_pkg::POS_W'(apsl_pkg::MAX_BYTES);
        hdr     = !ovf_now && (pos_reg >= apsl_pkg::POS_W'(4)) &&
                  (hc_reg < apsl_pkg::HC_W'(apsl_pkg::MAX_NALS)) &&
                  (win_reg[0] == 8'h01) && (win_reg[1] == 8'h00) && (win_reg[2] == 8'h00);
        typ     = hevc_mode ? word.data_byte[6:1] : {1'b0, word.data_byte[4:0]};
        cut     = (win_reg[3] == 8'h00) ? 3'd4 : 3'd3;
        end1    = pos_reg - apsl_pkg::POS_W'(cut);
        len1    = end1 - apsl_pkg::POS_W'(offs_reg[0]);

        cur.stop     = stop_reg;
        cur.best_off = best_off_reg;
        cur.best_len = best_len_reg;
        cl1          = cur;
        if (hdr && (hc_reg != '0))
        begin
            cl1 = close_nal(cur, hevc_mode, hc_reg, types_reg[0], types_reg[1],
                            types_reg[2], offs_reg[1], offs_reg[2], end1, len1);
        end

        types_next = types_reg;
        offs_next  = offs_reg;
        hc_next    = hc_reg;
        if (hdr)
        begin
            types_next[2] = types_reg[1];
            types_next[1] = types_reg[0];
            types_next[0] = typ;
            offs_next[2]  = offs_reg[1];
            offs_next[1]  = offs_reg[0];
            offs_next[0]  = pos_reg[apsl_pkg::OFF_W-1:0];
            hc_next       = hc_reg + 1'b1;
        end

        win_next = win_reg;
        pos_next = pos_reg;
        if (!ovf_now)
        begin
            win_next[3] = win_reg[2];
            win_next[2] = win_reg[1];
            win_next[1] = win_reg[0];
            win_next[0] = word.data_byte;
            pos_next    = pos_reg + 1'b1;
        end
        ovf_next = ovf_reg || ovf_now;

        // end of buffer: the newest nal runs to the last byte
        len2     = pos_next - apsl_pkg::POS_W'(offs_next[0]);
        final_ok = !ovf_next && (pos_next >= apsl_pkg::POS_W'(8));
        cl2      = cl1;
        if (final_ok && (hc_next != '0))
        begin
            cl2 = close_nal(cl1, hevc_mode, hc_next, types_next[0], types_next[1],
                            types_next[2], offs_next[1], offs_next[2], pos_next, len2);
        end
        found_c = final_ok && (cl2.best_len != '0);
        off_c   = found_c ? (cl2.best_off - apsl_pkg::OFF_W'(3)) : '0;
        len_c   = found_c ? (cl2.best_len + apsl_pkg::LEN_W'(3)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '{default: '0};
            pos_reg       <= '0;
            hc_reg        <= '0;
            types_reg     <= '{default: '0};
            offs_reg      <= '{default: '0};
            stop_reg      <= 1'b0;
            best_off_reg  <= '0;
            best_len_reg  <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (word.last_byte)
                begin
                    win_reg      <= '{default: '0};
                    pos_reg      <= '0;
                    hc_reg       <= '0;
                    types_reg    <= '{default: '0};
                    offs_reg     <= '{default: '0};
                    stop_reg     <= 1'b0;
                    best_off_reg <= '0;
                    best_len_reg <= '0;
                    ovf_reg      <= 1'b0;
                end
                else
                begin
                    win_reg      <= win_next;
                    pos_reg      <= pos_next;
                    hc_reg       <= hc_next;
                    types_reg    <= types_next;
                    offs_reg     <= offs_next;
                    stop_reg     <= cl1.stop;
                    best_off_reg <= cl1.best_off;
                    best_len_reg <= cl1.best_len;
                    ovf_reg      <= ovf_next;
                end
            end
            if (take && word.last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && word.last_byte)
        begin
            found_reg        <= found_c;
            start_offset_reg <= off_c;
            total_length_reg <= len_c;
            too_long_reg     <= ovf_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.found        = found_reg;
    assign results.start_offset = start_offset_reg;
    assign results.total_length = total_length_reg;
    assign results.too_long     = too_long_reg;

endmodule

@@ design/annexb_parameter_set_locator_unit.sv @@
// ----------------------------------------------------------------------------
// annexb_parameter_set_locator_unit
// locates the sps/pps (or vps/sps/pps) group in one annex b access unit
//
//   channel   dir   handshake       payload
//   bytes     in    valid/ready     data_byte, last_byte
//   results   out   valid/ready     found, start_offset, total_length, too_long
//   apb       in    psel/penable    hevc_mode at byte address 0
//
// one byte per cycle sustained; the scan state updates in the single stage
// after the input register
// a result is held in the result register once the last byte has passed the input register
// a waiting result stalls only a following last byte, other bytes flow on
// reset clears all scan state and selects h.264 mode
// ----------------------------------------------------------------------------
module annexb_parameter_set_locator_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [apsl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [apsl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [apsl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    apsl_in_if.sink                         bytes,
    apsl_out_if.source                      results
);

    logic            hevc_mode;
    logic            word_valid;
    logic            take;
    apsl_pkg::word_t word;

    apsl_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .hevc_mode (hevc_mode)
    );

    apsl_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    apsl_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .hevc_mode  (hevc_mode),
        .word_valid (word_valid),
        .word       (word),
        .take       (take),
        .results    (results)
    );

endmodule

@@ design/apsl_checker.sv @@
// ----------------------------------------------------------------------------
// apsl_checker
// port level checks on the result channel of the locator
// ----------------------------------------------------------------------------
`include "annexb_parameter_set_locator_unit_defines.svh"

module apsl_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic                       found,
    input logic [apsl_pkg::OFF_W-1:0] start_offset,
    input logic [apsl_pkg::LEN_W-1:0] total_length,
    input logic                       too_long
);

    `APSL_ASSERT_SAME(a_empty_zero, res_valid && !found, (start_offset == '0) && (total_length == '0), "no match but nonzero range")
    `APSL_ASSERT_SAME(a_found_len, res_valid && found, total_length >= apsl_pkg::LEN_W'(4), "match range too short")
    `APSL_ASSERT_SAME(a_long_nomatch, res_valid && too_long, !found, "overlong buffer reported a match")
    `APSL_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

endmodule

bind annexb_parameter_set_locator_unit apsl_checker u_apsl_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .found        (results.found),
    .start_offset (results.start_offset),
    .total_length (results.total_length),
    .too_long     (results.too_long)
);

@@ test/annexb_parameter_set_locator_unit_test.sv @@
// ----------------------------------------------------------------------------
// annexb_parameter_set_locator_unit_test
// self-checking bench for the annex b parameter set locator
// scoreboard rescans every accepted byte and predicts each result word
// directed cases first: plain match in both modes, zero-length nal, short buffer
// random access units follow in both modes under several idle and stall profiles
// ----------------------------------------------------------------------------
module annexb_parameter_set_locator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       found;
        logic [apsl_pkg::OFF_W-1:0] start_offset;
        logic [apsl_pkg::LEN_W-1:0] total_length;
        logic                       too_long;
    } group_t;

    class param_set_tracker;
        bit                          hevc_sel;
        logic [7:0]                  window [4];
        logic [apsl_pkg::POS_W-1:0]  pos_count;
        logic [apsl_pkg::HC_W-1:0]   hdr_count;
        bit                          halted;
        logic [apsl_pkg::TYPE_W-1:0] nal_type [3];
        logic [apsl_pkg::POS_W-1:0]  nal_pos [3];
        logic [apsl_pkg::POS_W-1:0]  grp_off;
        logic [apsl_pkg::LEN_W-1:0]  grp_len;
        bit                          overflow;
        group_t                      expected_groups [$];
        int                          mismatches;

        function new();
            hevc_sel   = 1'b0;
            mismatches = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            for (int k = 0; k < 4; k++)
                window[k] = 8'h00;
            for (int k = 0; k < 3; k++)
            begin
                nal_type[k] = '0;
                nal_pos[k]  = '0;
            end
            pos_count = '0;
            hdr_count = '0;
            halted    = 1'b0;
            grp_off   = '0;
            grp_len   = '0;
            overflow  = 1'b0;
        endfunction

        // newest nal is complete, ending at end_pos
        function void close_nal(logic [apsl_pkg::POS_W-1:0] end_pos,
                                logic [apsl_pkg::LEN_W-1:0] nal_len);
            if (hdr_count < 2 || halted)
                return;
            if (nal_len == 0)
            begin
                halted = 1'b1;
                return;
            end
            if (hevc_sel)
            begin
                if (nal_type[0] == apsl_pkg::HEVC_PPS && nal_type[1] == apsl_pkg::HEVC_SPS &&
                    hdr_count >= 3 && nal_type[2] == apsl_pkg::HEVC_VPS)
                begin
                    grp_off = nal_pos[2];
                    grp_len = end_pos - nal_pos[2];
                end
            end
            else if (nal_type[0] == apsl_pkg::H264_PPS && nal_type[1] == apsl_pkg::H264_SPS)
            begin
                grp_off = nal_pos[1];
                grp_len = end_pos - nal_pos[1];
            end
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            logic [apsl_pkg::TYPE_W-1:0] t;
            logic [apsl_pkg::POS_W-1:0]  stop;
            group_t                      g;
            if (pos_count >= apsl_pkg::MAX_BYTES)
                overflow = 1'b1;
            else
            begin
                if (pos_count >= 4 && hdr_count < apsl_pkg::MAX_NALS &&
                    window[0] == 8'h01 && window[1] == 8'h00 && window[2] == 8'h00)
                begin
                    t = hevc_sel ? b[6:1] : {1'b0, b[4:0]};
                    if (hdr_count >= 1)
                    begin
                        stop = pos_count - ((window[3] == 8'h00) ? apsl_pkg::POS_W'(4)
                                                                 : apsl_pkg::POS_W'(3));
                        close_nal(stop, stop - nal_pos[0]);
                    end
                    nal_type[2] = nal_type[1];
                    nal_type[1] = nal_type[0];
                    nal_type[0] = t;
                    nal_pos[2]  = nal_pos[1];
                    nal_pos[1]  = nal_pos[0];
                    nal_pos[0]  = pos_count;
                    hdr_count++;
                end
                window[3] = window[2];
                window[2] = window[1];
                window[1] = window[0];
                window[0] = b;
                pos_count++;
            end
            if (!last)
                return;
            g = '0;
            if (!overflow && pos_count >= 8)
            begin
                if (hdr_count >= 1)
                    close_nal(pos_count, pos_count - nal_pos[0]);
                if (grp_len > 0)
                begin
                    g.found        = 1'b1;
                    g.start_offset = apsl_pkg::OFF_W'(grp_off - apsl_pkg::POS_W'(3));
                    g.total_length = grp_len + apsl_pkg::LEN_W'(3);
                end
            end
            g.too_long = overflow;
            expected_groups.push_back(g);
            clear_scan();
        endfunction

        function void check_group(group_t got);
            group_t want;
            if (expected_groups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: found=%0d off=%0d len=%0d too_long=%0d",
                             got.found, got.start_offset, got.total_length, got.too_long);
                return;
            end
            want = expected_groups.pop_front();
            if (got.found !== want.found || got.start_offset !== want.start_offset ||
                got.total_length !== want.total_length || got.too_long !== want.too_long)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.found, want.start_offset, want.total_length,
                             want.too_long, got.found, got.start_offset,
                             got.total_length, got.too_long);
            end
        endfunction

        function int pending();
            return expected_groups.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [apsl_pkg::APB_ADDR_W-1:0] paddr;
    logic [apsl_pkg::APB_DATA_W-1:0] pwdata;
    logic [apsl_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    apsl_in_if  bytes_ch ();
    apsl_out_if results_ch ();

    param_set_tracker board = new();

    logic [7:0] au_bytes [$];
    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    int         hold_left     = 0;

    annexb_parameter_set_locator_unit u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bytes   (bytes_ch),
        .results (results_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic offer_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < src_idle_pct)
        begin
            bytes_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= b;
        bytes_ch.last_byte <= l;
        do
            @(posedge clk);
        while (!bytes_ch.ready);
        board.take_byte(b, l);
    endtask

    task automatic push_unit();
        for (int i = 0; i < au_bytes.size(); i++)
            offer_byte(au_bytes[i], i == au_bytes.size() - 1);
        au_bytes.delete();
    endtask

    task automatic drain();
        bytes_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {apsl_pkg::REG_HEVC_MODE, 2'b00};
        pwdata  <= {{(apsl_pkg::APB_DATA_W-1){1'b0}}, m};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.hevc_sel = m;
    endtask

    function automatic void put_start(input bit four);
        if (four)
            au_bytes.push_back(8'h00);
        au_bytes.push_back(8'h00);
        au_bytes.push_back(8'h00);
        au_bytes.push_back(8'h01);
    endfunction

    function automatic void put_nal(input logic [apsl_pkg::TYPE_W-1:0] t, input bit hevc,
                                    input int payload);
        logic [7:0] hdr;
        hdr = 8'($urandom);
        if (hevc)
            hdr[6:1] = t;
        else
            hdr[4:0] = t[4:0];
        au_bytes.push_back(hdr);
        repeat (payload) au_bytes.push_back(8'($urandom));
    endfunction

    // zero and one heavy so start codes show up by chance
    function automatic void put_noise();
        int r;
        r = $urandom_range(3);
        au_bytes.push_back(r == 0 ? 8'h00 : (r == 1 ? 8'h01 : 8'($urandom)));
    endfunction

    function automatic void put_group(input bit hevc);
        if (hevc)
        begin
            put_start(1'($urandom_range(1)));
            put_nal(apsl_pkg::HEVC_VPS, 1'b1, $urandom_range(3));
            put_start(1'($urandom_range(1)));
            put_nal(apsl_pkg::HEVC_SPS, 1'b1, $urandom_range(3));
            put_start(1'($urandom_range(1)));
            put_nal(apsl_pkg::HEVC_PPS, 1'b1, $urandom_range(3));
        end
        else
        begin
            put_start(1'($urandom_range(1)));
            put_nal(apsl_pkg::H264_SPS, 1'b0, $urandom_range(3));
            put_start(1'($urandom_range(1)));
            put_nal(apsl_pkg::H264_PPS, 1'b0, $urandom_range(3));
        end
    endfunction

    function automatic void build_unit(input bit hevc);
        int kind;
        int r;
        kind = $urandom_range(99);
        au_bytes.delete();
        if (kind < 8)
            repeat ($urandom_range(1, 7)) put_noise();
        else if (kind < 16)
            repeat ($urandom_range(8, 40)) put_noise();
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                r = $urandom_range(9);
                if (r < 5)
                    put_group(hevc ^ ($urandom_range(7) == 0));
                else if (r == 5)
                    put_start(1'($urandom_range(1)));
                else
                begin
                    put_start(1'($urandom_range(1)));
                    if (r == 6)
                        put_nal(hevc ?
                                apsl_pkg::TYPE_W'(apsl_pkg::HEVC_VPS + $urandom_range(2)) :
                                apsl_pkg::TYPE_W'(apsl_pkg::H264_SPS + $urandom_range(1)),
                                hevc, $urandom_range(3));
                    else
                        put_nal(apsl_pkg::TYPE_W'($urandom), hevc, $urandom_range(3));
                end
            end
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 4)) put_noise();
        end
    endfunction

    initial
    begin
        group_t seen;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results_ch.valid && results_ch.ready)
            begin
                seen.found        = results_ch.found;
                seen.start_offset = results_ch.start_offset;
                seen.total_length = results_ch.total_length;
                seen.too_long     = results_ch.too_long;
                board.check_group(seen);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int units;
        int sent;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        bytes_ch.valid     <= 1'b0;
        bytes_ch.data_byte <= 8'h00;
        bytes_ch.last_byte <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // h.264 after reset: plain match, zero-length nal, one-byte buffer
        put_start(1'b1);
        put_nal(apsl_pkg::H264_SPS, 1'b0, 0);
        put_start(1'b0);
        put_nal(apsl_pkg::H264_PPS, 1'b0, 0);
        push_unit();
        put_start(1'b1);
        put_nal(apsl_pkg::H264_SPS, 1'b0, 1);
        put_start(1'b0);
        put_start(1'b0);
        put_nal(apsl_pkg::H264_PPS, 1'b0, 1);
        push_unit();
        au_bytes.push_back(8'hff);
        push_unit();

        drain();
        write_mode(1'b1);
        put_start(1'b1);
        put_nal(apsl_pkg::HEVC_VPS, 1'b1, 0);
        put_start(1'b0);
        put_nal(apsl_pkg::HEVC_SPS, 1'b1, 0);
        put_start(1'b0);
        put_nal(apsl_pkg::HEVC_PPS, 1'b1, 0);
        push_unit();

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_mode(1'(ph % 2));
            case (ph / 2)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 68;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 68;
                end
                default:
                begin
                    src_idle_pct  = 11;
                    snk_stall_pct = 11;
                end
            endcase
            units = 0;
            sent  = 0;
            while (sent < 32 || units < 2)
            begin
                build_unit(1'(ph % 2));
                sent += au_bytes.size();
                units++;
                push_unit();
                if (ph == 0 && units == 1)
                    hold_left = 250;
                if (ph == 5 && units == 1)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/apsl_pkg.sv
design/apsl_in_if.sv
design/apsl_out_if.sv
design/apsl_cfg.sv
design/apsl_in_stage.sv
design/apsl_core.sv
design/annexb_parameter_set_locator_unit.sv
design/apsl_checker.sv
test/annexb_parameter_set_locator_unit_test.sv
